// File: hw/rtl/masked_alpha_pixel_blend_unit_defines.svh
// assertion macros used by the port-level checker of the pixel blend unit
`ifndef MASKED_ALPHA_PIXEL_BLEND_UNIT_DEFINES_SVH
`define MASKED_ALPHA_PIXEL_BLEND_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MAPB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel blend check failed");

// delayed implication, disabled while reset is high
`define MAPB_ASSERT_TWO(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("pixel blend latency check failed");

`endif

// File: hw/rtl/mapb_pkg.sv
// types and constants of the masked alpha pixel blend unit
package mapb_pkg;

   typedef enum logic [2:0] {
      FMT_555  = 3'd0,
      FMT_565  = 3'd1,
      FMT_888  = 3'd2,
      FMT_8888 = 3'd3,
      FMT_8BIT = 3'd4
   } pix_fmt_type;

   localparam pix_fmt_type FMT_RESET = FMT_8888;

   localparam logic [15:0] KEY_555  = 16'h7C1F;
   localparam logic [15:0] KEY_565  = 16'hF81F;
   localparam logic [23:0] KEY_888  = 24'hFF00FF;
   localparam logic [31:0] KEY_8888 = 32'h00FF00FF;

   localparam logic [7:0] MASK_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [31:0] pixel;
      logic        write;
   } blend_result_type;

endpackage

// File: hw/rtl/mapb_chan_mix.sv
// one color channel: s + ((m * (d - s)) >>> 8), channels zero-extended to 8 bits
module mapb_chan_mix (
   input  logic [7:0] src_chan,
   input  logic [7:0] dst_chan,
   input  logic [7:0] mask,
   output logic [7:0] mix_chan
);
   logic signed [8:0]  diff;
   logic signed [17:0] prod;
   logic signed [9:0]  step;
   logic signed [9:0]  sum;

   assign diff = $signed({1'b0, dst_chan}) - $signed({1'b0, src_chan});
   assign prod = $signed({1'b0, mask}) * diff;
   // upper bits of the product are the floor of prod / 256
   assign step = prod[17:8];
   assign sum  = $signed({2'b00, src_chan}) + step;
   // result lies between src and dst, so it fits the channel
   assign mix_chan = sum[7:0];
endmodule

// File: hw/rtl/mapb_blend_core.sv
// unpack, blend, key test and repack of one pixel
module mapb_blend_core (
   input  mapb_pkg::pix_fmt_type      fmt,
   input  logic [31:0]                src,
   input  logic [31:0]                dst,
   input  logic [7:0]                 mask,
   output mapb_pkg::blend_result_type result
);
   import mapb_pkg::*;

   logic [7:0] src_r, src_g, src_b;
   logic [7:0] dst_r, dst_g, dst_b;
   logic [7:0] mix_r, mix_g, mix_b;
   logic       fmt_ok;
   logic       key_hit;
   logic [31:0] packed_pixel;
   logic        do_write;

   always_comb begin
      src_r   = 8'd0;
      src_g   = 8'd0;
      src_b   = 8'd0;
      dst_r   = 8'd0;
      dst_g   = 8'd0;
      dst_b   = 8'd0;
      fmt_ok  = 1'b1;
      key_hit = 1'b0;
      case (fmt)
         FMT_555: begin
            src_r   = {3'd0, src[14:10]};
            src_g   = {3'd0, src[9:5]};
            src_b   = {3'd0, src[4:0]};
            dst_r   = {3'd0, dst[14:10]};
            dst_g   = {3'd0, dst[9:5]};
            dst_b   = {3'd0, dst[4:0]};
            key_hit = (src[15:0] == KEY_555);
         end
         FMT_565: begin
            src_r   = {3'd0, src[15:11]};
            src_g   = {2'd0, src[10:5]};
            src_b   = {3'd0, src[4:0]};
            dst_r   = {3'd0, dst[15:11]};
            dst_g   = {2'd0, dst[10:5]};
            dst_b   = {3'd0, dst[4:0]};
            key_hit = (src[15:0] == KEY_565);
         end
         FMT_888: begin
            src_r   = src[23:16];
            src_g   = src[15:8];
            src_b   = src[7:0];
            dst_r   = dst[23:16];
            dst_g   = dst[15:8];
            dst_b   = dst[7:0];
            key_hit = (src[23:0] == KEY_888);
         end
         FMT_8888: begin
            src_r   = src[23:16];
            src_g   = src[15:8];
            src_b   = src[7:0];
            dst_r   = dst[23:16];
            dst_g   = dst[15:8];
            dst_b   = dst[7:0];
            key_hit = (src == KEY_8888);
         end
         default: begin
            // 8-bit and unused codes never write
            fmt_ok = 1'b0;
         end
      endcase
   end

   mapb_chan_mix u_mix_r (.src_chan(src_r), .dst_chan(dst_r), .mask(mask), .mix_chan(mix_r));
   mapb_chan_mix u_mix_g (.src_chan(src_g), .dst_chan(dst_g), .mask(mask), .mix_chan(mix_g));
   mapb_chan_mix u_mix_b (.src_chan(src_b), .dst_chan(dst_b), .mask(mask), .mix_chan(mix_b));

   always_comb begin
      case (fmt)
         FMT_555:  packed_pixel = {17'd0, mix_r[4:0], mix_g[4:0], mix_b[4:0]};
         FMT_565:  packed_pixel = {16'd0, mix_r[4:0], mix_g[5:0], mix_b[4:0]};
         FMT_888:  packed_pixel = {dst[31:24], mix_r, mix_g, mix_b};
         FMT_8888: packed_pixel = {8'd0, mix_r, mix_g, mix_b};
         default:  packed_pixel = dst;
      endcase
   end

   assign do_write     = fmt_ok && !key_hit && (mask != MASK_OPAQUE);
   assign result.write = do_write;
   assign result.pixel = do_write ? packed_pixel : dst;
endmodule

// File: hw/rtl/masked_alpha_pixel_blend_unit.sv
// an item taken into the input register reaches the rsp_ ports through the result register
// throughput: one item per cycle; busy stays low, so start may be high every cycle
// path: input register, one blend core (three 8x9 channel multiplies), result register
// reset: synchronous active high; clears the item valid and strobe, format returns to 32-bit
// the receiver cannot stall: strobe marks each result for exactly one cycle
module masked_alpha_pixel_blend_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_source_pixel,
   input  logic [31:0] req_dest_pixel,
   input  logic [7:0]  req_mask_alpha,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data,
   output logic        strobe,
   output logic [31:0] rsp_blended_pixel,
   output logic        rsp_write_enable
);
   import mapb_pkg::*;

   pix_fmt_type      fmt_ff, fmt_in;
   logic             in_valid_ff, in_valid_in;
   logic [31:0]      src_ff, dst_ff;
   logic [7:0]       mask_ff;
   logic             strobe_ff;
   logic [31:0]      pixel_ff;
   logic             we_ff;
   blend_result_type result;

   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;
   assign fmt_in      = csr_write_enable ? pix_fmt_type'(csr_write_data) : fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff      <= FMT_RESET;
         in_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         fmt_ff      <= fmt_in;
         in_valid_ff <= in_valid_in;
         strobe_ff   <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         src_ff  <= req_source_pixel;
         dst_ff  <= req_dest_pixel;
         mask_ff <= req_mask_alpha;
      end
      if (in_valid_ff) begin
         pixel_ff <= result.pixel;
         we_ff    <= result.write;
      end
   end

   mapb_blend_core u_core (
      .fmt    (fmt_ff),
      .src    (src_ff),
      .dst    (dst_ff),
      .mask   (mask_ff),
      .result (result)
   );

   assign strobe            = strobe_ff;
   assign rsp_blended_pixel = pixel_ff;
   assign rsp_write_enable  = we_ff;
endmodule

// File: hw/rtl/mapb_checker.sv
// port-level checks of the pixel blend unit, bound to the top level
`include "masked_alpha_pixel_blend_unit_defines.svh"

module mapb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_dest_pixel,
   input logic [7:0]  req_mask_alpha,
   input logic        strobe,
   input logic [31:0] rsp_blended_pixel,
   input logic        rsp_write_enable
);
   import mapb_pkg::*;

   // every accepted item comes back with a strobe
   `MAPB_ASSERT_TWO(a_item_returns, clock, reset, start && !busy, strobe)

   // a skipped pixel hands back the destination unchanged
   `MAPB_ASSERT_NOW(a_skip_keeps_dest, clock, reset,
      strobe && !rsp_write_enable, rsp_blended_pixel == $past(req_dest_pixel, 2))

   // an opaque mask never writes
   `MAPB_ASSERT_NOW(a_opaque_no_write, clock, reset,
      strobe && ($past(req_mask_alpha, 2) == MASK_OPAQUE), !rsp_write_enable)
endmodule

bind masked_alpha_pixel_blend_unit mapb_checker u_mapb_checker (.*);

// File: tb/sv/masked_alpha_pixel_blend_unit_checker.sv
`timescale 1ns / 100ps
// checker for the pixel blend unit: predicts every blended pixel and compares the results
module masked_alpha_pixel_blend_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_source_pixel,
   input  logic [31:0] req_dest_pixel,
   input  logic [7:0]  req_mask_alpha,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data,
   input  logic        strobe,
   input  logic [31:0] rsp_blended_pixel,
   input  logic        rsp_write_enable,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);
   import mapb_pkg::*;

   logic [2:0] pixel_format;
   blend_result_type blend_expect_q[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
      pixel_format   = FMT_RESET;
   end

   // floor blend of one channel: s + ((m * (d - s)) >>> 8)
   function automatic logic [7:0] mix_chan(input logic [7:0] s, input logic [7:0] d,
                                           input logic [7:0] m);
      int diff;
      int prod;
      diff = int'(d) - int'(s);
      prod = int'(m) * diff;
      return 8'(int'(s) + (prod >>> 8));
   endfunction

   function automatic blend_result_type predict_blend(input logic [2:0] fmt,
                                                      input logic [31:0] s,
                                                      input logic [31:0] d,
                                                      input logic [7:0] m);
      blend_result_type res;
      logic [7:0] ch_r;
      logic [7:0] ch_g;
      logic [7:0] ch_b;
      res.pixel = d;
      res.write = 1'b0;
      if (m != MASK_OPAQUE) begin
         case (fmt)
            FMT_555: begin
               if (s[15:0] != KEY_555) begin
                  ch_r = mix_chan({3'd0, s[14:10]}, {3'd0, d[14:10]}, m);
                  ch_g = mix_chan({3'd0, s[9:5]}, {3'd0, d[9:5]}, m);
                  ch_b = mix_chan({3'd0, s[4:0]}, {3'd0, d[4:0]}, m);
                  res.pixel = {17'd0, ch_r[4:0], ch_g[4:0], ch_b[4:0]};
                  res.write = 1'b1;
               end
            end
            FMT_565: begin
               if (s[15:0] != KEY_565) begin
                  ch_r = mix_chan({3'd0, s[15:11]}, {3'd0, d[15:11]}, m);
                  ch_g = mix_chan({2'd0, s[10:5]}, {2'd0, d[10:5]}, m);
                  ch_b = mix_chan({3'd0, s[4:0]}, {3'd0, d[4:0]}, m);
                  res.pixel = {16'd0, ch_r[4:0], ch_g[5:0], ch_b[4:0]};
                  res.write = 1'b1;
               end
            end
            FMT_888, FMT_8888: begin
               if ((fmt == FMT_888 && s[23:0] != KEY_888) ||
                   (fmt == FMT_8888 && s != KEY_8888)) begin
                  ch_r = mix_chan(s[23:16], d[23:16], m);
                  ch_g = mix_chan(s[15:8], d[15:8], m);
                  ch_b = mix_chan(s[7:0], d[7:0], m);
                  // 24-bit keeps the destination top byte, 32-bit clears it
                  res.pixel = {(fmt == FMT_888) ? d[31:24] : 8'd0, ch_r, ch_g, ch_b};
                  res.write = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   always @(posedge clock) begin
      blend_result_type want;
      if (reset) begin
         pixel_format = FMT_RESET;
         blend_expect_q.delete();
      end else begin
         if (strobe) begin
            if (blend_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no item outstanding: pixel %h write %b",
                           $realtime, rsp_blended_pixel, rsp_write_enable);
            end else begin
               want = blend_expect_q.pop_front();
               checked_count++;
               if (rsp_blended_pixel !== want.pixel || rsp_write_enable !== want.write) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch: expected pixel %h write %b, got pixel %h write %b",
                              $realtime, want.pixel, want.write,
                              rsp_blended_pixel, rsp_write_enable);
               end
            end
         end
         if (start && !busy)
            blend_expect_q.push_back(predict_blend(pixel_format, req_source_pixel,
                                                   req_dest_pixel, req_mask_alpha));
         if (csr_write_enable)
            pixel_format = csr_write_data;
      end
      pending_count = blend_expect_q.size();
   end

endmodule

// File: tb/sv/masked_alpha_pixel_blend_unit_test.sv
`timescale 1ns / 100ps
// testbench top: drives pixel items and format writes into the blend unit and reports the verdict
module masked_alpha_pixel_blend_unit_test;
   import mapb_pkg::*;

   localparam int IDLE_LIMIT      = 500;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PHASE_COUNT     = 14;
   localparam logic [2:0] FMT_UNUSED_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_source_pixel;
   logic [31:0] req_dest_pixel;
   logic [7:0]  req_mask_alpha;
   logic        csr_write_enable;
   logic [2:0]  csr_write_data;
   logic        strobe;
   logic [31:0] rsp_blended_pixel;
   logic        rsp_write_enable;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int items_sent;
   int format_writes;
   int idle_cycles;

   masked_alpha_pixel_blend_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_source_pixel  (req_source_pixel),
      .req_dest_pixel    (req_dest_pixel),
      .req_mask_alpha    (req_mask_alpha),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .strobe            (strobe),
      .rsp_blended_pixel (rsp_blended_pixel),
      .rsp_write_enable  (rsp_write_enable)
   );

   masked_alpha_pixel_blend_unit_checker blend_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_source_pixel  (req_source_pixel),
      .req_dest_pixel    (req_dest_pixel),
      .req_mask_alpha    (req_mask_alpha),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .strobe            (strobe),
      .rsp_blended_pixel (rsp_blended_pixel),
      .rsp_write_enable  (rsp_write_enable),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: cycles with neither an item taken nor a result out
   always @(posedge clock) begin
      if (reset || (start && !busy) || strobe) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst,
                             input logic [7:0] mask);
      @(negedge clock);
      start            <= 1'b1;
      req_source_pixel <= src;
      req_dest_pixel   <= dst;
      req_mask_alpha   <= mask;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // stop sending and wait until every result is back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_format(input logic [2:0] fmt);
      drain();
      csr_write_data   <= fmt;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      format_writes++;
   endtask

   function automatic logic [31:0] format_key(input logic [2:0] fmt);
      case (fmt)
         FMT_555:  return {16'd0, KEY_555};
         FMT_565:  return {16'd0, KEY_565};
         FMT_888:  return {8'd0, KEY_888};
         FMT_8888: return KEY_8888;
         default:  return $urandom;
      endcase
   endfunction

   // key with the bits above the compared width set; 32-bit and other codes flip bit 24 instead
   function automatic logic [31:0] key_upper_set(input logic [2:0] fmt);
      case (fmt)
         FMT_555, FMT_565: return format_key(fmt) | 32'hFFFF0000;
         FMT_888:          return format_key(fmt) | 32'hFF000000;
         default:          return format_key(fmt) ^ 32'h01000000;
      endcase
   endfunction

   function automatic logic [31:0] pick_source(input logic [2:0] fmt);
      int r;
      logic [31:0] junk;
      r = $urandom_range(0, 15);
      junk = $urandom;
      if (r < 2) begin
         case (fmt)
            FMT_555, FMT_565: return format_key(fmt) | {junk[15:0], 16'd0};
            FMT_888:          return format_key(fmt) | {junk[7:0], 24'd0};
            default:          return format_key(fmt);
         endcase
      end else if (r == 2) begin
         // one bit away from the key
         return format_key(fmt) ^ (32'd1 << $urandom_range(0, 31));
      end
      return junk;
   endfunction

   function automatic logic [7:0] pick_mask();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0, 1:    return MASK_OPAQUE;
         2, 3:    return 8'd0;
         4:       return 8'd254;
         5:       return 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      logic [2:0] directed_fmts [6];
      logic [2:0] fmt;
      bit no_gaps;
      reset            = 1'b1;
      start            = 1'b0;
      req_source_pixel = '0;
      req_dest_pixel   = '0;
      req_mask_alpha   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      items_sent       = 0;
      format_writes    = 0;
      idle_cycles      = 0;
      directed_fmts = '{FMT_8888, FMT_555, FMT_565, FMT_888, FMT_8BIT, FMT_UNUSED_HI};
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: exact key, key with upper bits, extreme pixels and masks per format
      foreach (directed_fmts[i]) begin
         set_format(directed_fmts[i]);
         send_pixel(format_key(directed_fmts[i]), $urandom, 8'd0);
         send_pixel(key_upper_set(directed_fmts[i]), 32'hFFFFFFFF, 8'd0);
         send_pixel(32'h00000000, 32'hFFFFFFFF, 8'd254);
         send_pixel(32'hFFFFFFFF, 32'h00000000, MASK_OPAQUE);
      end

      // random phases: every format code once, then a random mix
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 8)
            fmt = 3'(phase);
         else if ($urandom_range(0, 4) == 0)
            fmt = 3'($urandom_range(4, 7));
         else
            fmt = 3'($urandom_range(0, 3));
         set_format(fmt);
         no_gaps = (phase % 3 == 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_pixel(pick_source(fmt), $urandom, pick_mask());
            if (!no_gaps)
               idle_gap(pick_gap());
         end
      end

      drain();
      repeat (10) @(negedge clock);
      $display("covered %0d pixel items under %0d format writes (all eight codes)",
               items_sent, format_writes);
      $display("%0d results checked, %0d mismatches", checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
